FILE: hdl/assert_macros.svh
// Assertion macros shared by the page watch bitmap RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never hold while out of reset.
`define PWB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Flag a consequent that fails in the same cycle as its antecedent.
`define PWB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Flag a consequent that fails in the cycle after its antecedent.
`define PWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pwb_pkg.sv
// Package of constants and types for the page watch bitmap.
`default_nettype none

package pwb_pkg;

    localparam int ADDR_BITS         = 32;
    localparam int PAGE_OFFSET_BITS  = 12;
    localparam int BITS_PER_WORD_LOG = 3;

    localparam int PAGE_W      = ADDR_BITS - PAGE_OFFSET_BITS;
    localparam int WORD_ADDR_W = PAGE_W - BITS_PER_WORD_LOG;
    localparam int WORD_W      = 1 << BITS_PER_WORD_LOG;
    localparam int IN_ADDR_W   = 32;
    localparam int FLAGS_W     = 2;
    localparam int CHANGES_W   = 21;

    // Bit select within one bitmap word
    localparam logic [BITS_PER_WORD_LOG-1:0] BIT_SEL_MASK = '1;

    // Item kinds
    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_ADD   = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [PAGE_W-1:0]    first_page;
        logic [PAGE_W-1:0]    last_page;
        logic [FLAGS_W-1:0]   flags;
    } pwb_item_t;

    typedef struct packed {
        logic                 fault;
        logic [CHANGES_W-1:0] changes;
    } pwb_result_t;

    typedef struct packed {
        logic                   idle;
        logic                   clearing;
        logic                   res_valid;
    } pwb_status_t;

    typedef struct packed {
        logic                   rd_en;
        logic [WORD_ADDR_W-1:0] rd_addr;
        logic                   wr_en;
        logic [WORD_ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]      wr_data;
    } pwb_mem_req_t;

endpackage

`default_nettype wire

FILE: hdl/pwb_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module pwb_ram #(
    parameter int ADDR_W = 17,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pwb_walk.sv
// Range walker: clearing pass, word-by-word bitmap read for checks and read-modify-write for adds.
`default_nettype none

module pwb_walk (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire pwb_pkg::pwb_item_t           item,
    input  wire logic                         res_take,
    input  wire logic [pwb_pkg::WORD_W-1:0]   rd_data,
    output pwb_pkg::pwb_mem_req_t             mem_req,
    output pwb_pkg::pwb_status_t              status,
    output pwb_pkg::pwb_result_t              result
);
    import pwb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [WORD_ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                     issued_all_reg, issued_all_next;
    logic                     pend_reg, pend_next;

    logic                     kind_reg, kind_next;
    logic [PAGE_W-1:0]        first_page_reg, first_page_next;
    logic [PAGE_W-1:0]        last_page_reg, last_page_next;
    logic [WORD_ADDR_W-1:0]   rd_word_reg, rd_word_next;
    logic [WORD_ADDR_W-1:0]   pend_word_reg, pend_word_next;
    logic                     fault_reg, fault_next;
    logic [CHANGES_W-1:0]     changes_reg, changes_next;

    logic [WORD_ADDR_W-1:0]   first_word;
    logic [WORD_ADDR_W-1:0]   last_word;
    logic [BITS_PER_WORD_LOG-1:0] lo_bit;
    logic [BITS_PER_WORD_LOG-1:0] hi_bit;
    logic [WORD_W-1:0]        mask;
    logic [WORD_W-1:0]        new_bits;
    logic                     hit;
    logic                     issue;
    logic                     last_proc;
    logic                     skip_item;

    // Bits lo..hi set within one word
    function automatic logic [WORD_W-1:0] word_mask(
        input logic [BITS_PER_WORD_LOG-1:0] lo,
        input logic [BITS_PER_WORD_LOG-1:0] hi
    );
        logic [WORD_W-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (BIT_SEL_MASK - hi));
    endfunction

    // Count the set bits of one word
    function automatic logic [BITS_PER_WORD_LOG:0] pop_count(
        input logic [WORD_W-1:0] w
    );
        logic [BITS_PER_WORD_LOG:0] cnt;
        cnt = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            cnt = cnt + {{BITS_PER_WORD_LOG{1'b0}}, w[i]};
        end
        return cnt;
    endfunction

    // Mask of the word now returning from memory
    always_comb
    begin
        first_word = first_page_reg[PAGE_W-1:BITS_PER_WORD_LOG];
        last_word  = last_page_reg[PAGE_W-1:BITS_PER_WORD_LOG];
        lo_bit     = (pend_word_reg == first_word) ?
                     first_page_reg[BITS_PER_WORD_LOG-1:0] : '0;
        hi_bit     = (pend_word_reg == last_word) ?
                     last_page_reg[BITS_PER_WORD_LOG-1:0] : BIT_SEL_MASK;
        mask       = word_mask(lo_bit, hi_bit);
        new_bits   = ~rd_data & mask;
        hit        = |(rd_data & mask);
        issue      = (state_reg == S_WALK) && !issued_all_reg;
        last_proc  = pend_reg && (pend_word_reg == last_word);
        skip_item  = (item.first_page > item.last_page) ||
                     ((item.kind == KIND_ADD) && (item.flags == '0));
    end

    // Drive memory ports: clearing writes zero, adds write the merged word back
    always_comb
    begin
        mem_req.rd_en   = issue;
        mem_req.rd_addr = rd_word_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_addr_reg;
            mem_req.wr_data = '0;
        end
        else
        begin
            mem_req.wr_en   = pend_reg && (kind_reg == KIND_ADD);
            mem_req.wr_addr = pend_word_reg;
            mem_req.wr_data = rd_data | mask;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        issued_all_next = issued_all_reg;
        pend_next       = 1'b0;
        kind_next       = kind_reg;
        first_page_next = first_page_reg;
        last_page_next  = last_page_reg;
        rd_word_next    = rd_word_reg;
        pend_word_next  = pend_word_reg;
        fault_next      = fault_reg;
        changes_next    = changes_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next       = item.kind;
                    first_page_next = item.first_page;
                    last_page_next  = item.last_page;
                    rd_word_next    = item.first_page[PAGE_W-1:BITS_PER_WORD_LOG];
                    issued_all_next = 1'b0;
                    fault_next      = 1'b0;
                    changes_next    = '0;
                    state_next      = skip_item ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                // Advance the read pointer, stop at the last word
                if (issue)
                begin
                    rd_word_next   = rd_word_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_word_next = rd_word_reg;
                    if (rd_word_reg == last_word)
                    begin
                        issued_all_next = 1'b1;
                    end
                end
                // Retire the returning word
                if (pend_reg)
                begin
                    if (kind_reg == KIND_ADD)
                    begin
                        changes_next = changes_reg + CHANGES_W'(pop_count(new_bits));
                    end
                    if ((kind_reg == KIND_CHECK) && hit)
                    begin
                        fault_next = 1'b1;
                        state_next = S_DONE;
                        pend_next  = 1'b0;
                    end
                    else if (last_proc)
                    begin
                        state_next = S_DONE;
                        pend_next  = 1'b0;
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            issued_all_reg <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issued_all_reg <= issued_all_next;
            pend_reg       <= pend_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        first_page_reg <= first_page_next;
        last_page_reg  <= last_page_next;
        rd_word_reg    <= rd_word_next;
        pend_word_reg  <= pend_word_next;
        fault_reg      <= fault_next;
        changes_reg    <= changes_next;
    end

    assign status.idle      = (state_reg == S_IDLE);
    assign status.clearing  = (state_reg == S_CLEAR);
    assign status.res_valid = (state_reg == S_DONE);
    assign result.fault     = fault_reg;
    assign result.changes   = changes_reg;

endmodule

`default_nettype wire

FILE: hdl/page_watch_bitmap_unit.sv
// Top level of the page watch bitmap: walker, bitmap RAM and result register.
//
//  Channel  Signals                                       Direction
//  in       in_valid/in_ready, kind, first_addr,          into block
//           last_addr, watch_flags
//  out      out_valid/out_ready, fault, changes           out of block
//
// After reset the bitmap RAM is swept to zero, one word a cycle, all
// 131072 words, with in_ready low.
// An item is walked over the bitmap words its page range spans (8 pages a
// word, one RAM read, and for an add a write-back, a word a cycle); an empty
// range, or an add with zero flags, goes straight to the result without a
// RAM access. A check stops at the first watched word.
// The result register lets the walker take the next transaction while a
// result waits on out_ready.
`default_nettype none
`include "assert_macros.svh"

module page_watch_bitmap_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [pwb_pkg::IN_ADDR_W-1:0]   first_addr,
    input  wire logic [pwb_pkg::IN_ADDR_W-1:0]   last_addr,
    input  wire logic [pwb_pkg::FLAGS_W-1:0]     watch_flags,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 fault,
    output logic [pwb_pkg::CHANGES_W-1:0]        changes
);
    import pwb_pkg::*;

    pwb_item_t             item;
    pwb_mem_req_t          mem_req;
    pwb_status_t           status;
    pwb_result_t           result;
    logic [WORD_W-1:0]     rd_data;
    logic                  start;
    logic                  res_take;
    logic                  out_valid_reg, out_valid_next;
    logic                  fault_reg;
    logic [CHANGES_W-1:0]  changes_reg;

    // Map byte addresses to page numbers
    assign item.kind       = kind;
    assign item.first_page = first_addr[ADDR_BITS-1:PAGE_OFFSET_BITS];
    assign item.last_page  = last_addr[ADDR_BITS-1:PAGE_OFFSET_BITS];
    assign item.flags      = watch_flags;

    assign in_ready = status.idle;
    assign start    = in_valid && in_ready;
    assign res_take = status.res_valid && (!out_valid_reg || out_ready);

    pwb_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .res_take (res_take),
        .rd_data  (rd_data),
        .mem_req  (mem_req),
        .status   (status),
        .result   (result)
    );

    pwb_ram #(
        .ADDR_W (WORD_ADDR_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data)
    );

    // Hold the result until the output transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            fault_reg   <= result.fault;
            changes_reg <= result.changes;
        end
    end

    assign out_valid = out_valid_reg;
    assign fault     = fault_reg;
    assign changes   = changes_reg;

    // Checks on the walker and RAM traffic
    `PWB_ASSERT_NEVER(a_no_same_word_rw, clk, rst_n, mem_req.rd_en && mem_req.wr_en && (mem_req.rd_addr == mem_req.wr_addr), "read and write of one bitmap word in one cycle")
    `PWB_ASSERT_IMPLY(a_no_accept_in_clear, clk, rst_n, status.clearing, !start, "transaction accepted during clearing pass")
    `PWB_ASSERT_IMPLY(a_fault_no_changes, clk, rst_n, out_valid && fault, changes == '0, "fault result carries a change count")
    `PWB_ASSERT_NEXT(a_take_fills_out, clk, rst_n, res_take, out_valid, "taken result not presented")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the page watch bitmap unit.
`timescale 1ns / 100ps

module tb_top;

    import pwb_pkg::*;

    localparam int          PAGE_COUNT     = 1 << PAGE_W;
    localparam int          HOT_SPAN       = 512;      // pages in one hot region
    localparam int          RANDOM_OPS     = 1300;
    localparam int          HOLD_CYCLES    = 300;      // long receiver hold-off
    localparam int          TAIL_CYCLES    = 64;
    localparam int          MAX_REPORTS    = 50;
    // The limit covers a clearing sweep or a full-range walk, during which
    // nothing is accepted.
    localparam int unsigned WATCHDOG_LIMIT = 400000;

    localparam logic [FLAGS_W-1:0] FLAGS_NONE = '0;

    typedef struct {
        logic                 kind;
        logic [IN_ADDR_W-1:0] first_addr;
        logic [IN_ADDR_W-1:0] last_addr;
        logic [FLAGS_W-1:0]   flags;
        bit                   hold_drain;   // wait for every result before offering
        bit                   no_gap;
    } page_op_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 kind        = KIND_CHECK;
    logic [IN_ADDR_W-1:0] first_addr  = '0;
    logic [IN_ADDR_W-1:0] last_addr   = '0;
    logic [FLAGS_W-1:0]   watch_flags = FLAGS_NONE;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic                 fault;
    logic [CHANGES_W-1:0] changes;

    page_op_t     op_q[$];
    pwb_result_t  result_q[$];
    bit           page_watched [0:PAGE_COUNT-1];
    int unsigned  error_count  = 0;
    int unsigned  send_gap;
    int unsigned  stall_left;
    int unsigned  hold_left;
    int unsigned  results_seen;
    int unsigned  mon_tick;
    bit           out_calm;
    int unsigned  idle_cycles  = 0;

    page_watch_bitmap_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .first_addr  (first_addr),
        .last_addr   (last_addr),
        .watch_flags (watch_flags),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fault       (fault),
        .changes     (changes)
    );

    // Clock and a single reset pulse
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Walk the page range of one transaction over the shadow bitmap
    function automatic pwb_result_t predict_page_op(logic k, logic [IN_ADDR_W-1:0] s,
                                                    logic [IN_ADDR_W-1:0] e,
                                                    logic [FLAGS_W-1:0] f);
        int unsigned first_pg;
        int unsigned last_pg;
        int unsigned p;
        pwb_result_t res;
        res      = '0;
        first_pg = int'(s >> PAGE_OFFSET_BITS) & (PAGE_COUNT - 1);
        last_pg  = int'(e >> PAGE_OFFSET_BITS) & (PAGE_COUNT - 1);
        if (first_pg <= last_pg)
        begin
            if (k == KIND_CHECK)
            begin
                for (p = first_pg; p <= last_pg && !res.fault; p++)
                    if (page_watched[p])
                        res.fault = 1'b1;
            end
            else if (f != FLAGS_NONE)
            begin
                for (p = first_pg; p <= last_pg; p++)
                begin
                    if (!page_watched[p])
                        res.changes = res.changes + 1'b1;
                    page_watched[p] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    task automatic push_op(input logic k, input logic [IN_ADDR_W-1:0] s,
                           input logic [IN_ADDR_W-1:0] e, input logic [FLAGS_W-1:0] f,
                           input bit hold, input bit calm);
        page_op_t op;
        op.kind       = k;
        op.first_addr = s;
        op.last_addr  = e;
        op.flags      = f;
        op.hold_drain = hold;
        op.no_gap     = calm;
        op_q.push_back(op);
    endtask

    // Driver: offer queued transactions, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin : drive_ops
        page_op_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                result_q.push_back(predict_page_op(kind, first_addr, last_addr, watch_flags));
            // hold the payload while it waits on in_ready
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (op_q.size() != 0 &&
                         (!op_q[0].hold_drain || (result_q.size() == 0 && !in_valid)))
                begin
                    nxt = op_q.pop_front();
                    in_valid    <= 1'b1;
                    kind        <= nxt.kind;
                    first_addr  <= nxt.first_addr;
                    last_addr   <= nxt.last_addr;
                    watch_flags <= nxt.flags;
                    send_gap    <= nxt.no_gap ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest prediction, pace out_ready
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        pwb_result_t want;
        bit          taken;
        int unsigned gap;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            results_seen <= 0;
            mon_tick     <= 0;
            out_calm     <= 1'b0;
        end
        else
        begin
            taken = out_valid && out_ready;
            mon_tick <= mon_tick + 1;
            if (mon_tick[6:0] == 0)
                out_calm <= ($urandom_range(0, 3) == 0);

            if (taken)
            begin
                results_seen <= results_seen + 1;
                if (result_q.size() == 0)
                    report_mismatch($sformatf("unexpected result fault=%0d changes=%0d",
                                              fault, changes));
                else
                begin
                    want = result_q.pop_front();
                    if (fault !== want.fault)
                        report_mismatch($sformatf("fault %0d, expected %0d",
                                                  fault, want.fault));
                    if (changes !== want.changes)
                        report_mismatch($sformatf("changes %0d, expected %0d",
                                                  changes, want.changes));
                end
            end

            // long hold-off twice in the run, else short random stalls
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (taken && (results_seen == 300 || results_seen == 1000))
            begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (taken && !out_calm)
            begin
                gap = pick_gap();
                stall_left <= (gap != 0) ? gap - 1 : 0;
                out_ready  <= (gap == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        logic [PAGE_W-1:0]    hot_base [0:7];
        int unsigned          first_pg;
        int unsigned          last_pg;
        int unsigned          r;
        int unsigned          span;
        logic [IN_ADDR_W-1:0] a;
        logic [IN_ADDR_W-1:0] b;
        logic [IN_ADDR_W:0]   wide;
        logic                 k;
        bit                   calm;

        // directed: extremes, empty ranges, zero flags, top page
        push_op(KIND_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, 2'b11, 0, 0);
        push_op(KIND_ADD,   32'h0000_0000, 32'h0000_0000, 2'b01, 0, 0);
        push_op(KIND_CHECK, 32'h0000_0000, 32'h0000_0FFF, 2'b00, 0, 0);
        push_op(KIND_CHECK, 32'h0000_1000, 32'h0000_1FFF, 2'b00, 0, 0);
        push_op(KIND_ADD,   32'h0000_0000, 32'h0000_7FFF, 2'b11, 0, 0);
        push_op(KIND_ADD,   32'h0000_5000, 32'h0000_AFFF, 2'b10, 0, 0);
        push_op(KIND_ADD,   32'h0002_0000, 32'h0002_FFFF, FLAGS_NONE, 0, 0);
        push_op(KIND_CHECK, 32'h0002_0000, 32'h0002_FFFF, 2'b01, 0, 0);
        push_op(KIND_ADD,   32'h0004_0000, 32'h0003_FFFF, 2'b11, 0, 0);
        push_op(KIND_CHECK, 32'h0000_1000, 32'h0000_0000, 2'b00, 0, 0);
        push_op(KIND_CHECK, 32'h0000_1FFF, 32'h0000_1000, 2'b00, 0, 0);
        push_op(KIND_ADD,   32'hFFFF_F000, 32'hFFFF_FFFF, 2'b01, 0, 0);
        push_op(KIND_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00, 0, 0);
        push_op(KIND_CHECK, 32'hFFFF_0000, 32'hFFFF_EFFF, 2'b10, 0, 0);
        push_op(KIND_ADD,   32'hFFFF_FFFF, 32'h0000_0000, 2'b11, 0, 0);
        push_op(KIND_CHECK, 32'h0000_3000, 32'h0000_3000, 2'b11, 0, 0);
        push_op(KIND_ADD,   32'h0000_7000, 32'h0001_0FFF, 2'b01, 0, 1);
        push_op(KIND_CHECK, 32'h0000_B000, 32'h0001_1FFF, 2'b00, 0, 1);
        push_op(KIND_ADD,   32'hFFFE_0ABC, 32'hFFFF_FFFF, 2'b10, 0, 1);
        push_op(KIND_CHECK, 32'hFFFD_0000, 32'hFFFD_FFFF, 2'b00, 0, 0);

        // hot regions so adds and checks overlap; bottom and top of the space
        hot_base[0] = '0;
        hot_base[1] = PAGE_W'(PAGE_COUNT - HOT_SPAN);
        for (int i = 2; i < 8; i++)
            hot_base[i] = PAGE_W'($urandom) & ~PAGE_W'(HOT_SPAN - 1);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            calm = ((i / 60) % 4 == 1);
            k    = 1'($urandom_range(0, 1));
            r    = $urandom_range(0, 99);
            if (r < 80)
            begin
                // well-formed range starting in a hot region
                first_pg = hot_base[$urandom_range(0, 7)] + $urandom_range(0, HOT_SPAN - 1);
                span     = $urandom_range(0, 99);
                if (span < 85)
                    span = $urandom_range(0, 15);
                else if (span < 98)
                    span = $urandom_range(16, 300);
                else
                    span = $urandom_range(300, 4000);
                last_pg = first_pg + span;
                if (last_pg > PAGE_COUNT - 1)
                    last_pg = PAGE_COUNT - 1;
                a = (IN_ADDR_W'(first_pg) << PAGE_OFFSET_BITS) | $urandom_range(0, 4095);
                b = (IN_ADDR_W'(last_pg) << PAGE_OFFSET_BITS) | $urandom_range(0, 4095);
            end
            else if (r < 90)
            begin
                // reversed or same-page range anywhere
                a = $urandom;
                b = $urandom;
                if ((a >> PAGE_OFFSET_BITS) < (b >> PAGE_OFFSET_BITS))
                begin
                    wide = {1'b0, a};
                    a    = b;
                    b    = wide[IN_ADDR_W-1:0];
                end
            end
            else
            begin
                // noise: arbitrary start, short forward span, clipped at the top
                a    = $urandom;
                wide = {1'b0, a} + $urandom_range(0, 32'h0002_0000);
                b    = wide[IN_ADDR_W] ? 32'hFFFF_FFFF : wide[IN_ADDR_W-1:0];
            end
            push_op(k, a, b, FLAGS_W'($urandom_range(0, 3)), (i == 650), calm);
        end

        // mark the whole space on a settled block, then check it
        push_op(KIND_ADD,   32'h0000_0000, 32'hFFFF_FFFF, 2'b01, 1, 0);
        push_op(KIND_CHECK, 32'h8000_0000, 32'h8000_0FFF, 2'b00, 0, 0);
        push_op(KIND_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, 2'b00, 0, 0);

        @(posedge rst_n);
        while (op_q.size() != 0 || in_valid)
            @(negedge clk);
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
